FILE: design/cluster_size_rank_mapper_macros.svh
// Assertion macros shared by the cluster size rank mapper.
// Included by the top level; needs no package.
`ifndef CLUSTER_SIZE_RANK_MAPPER_MACROS_SVH
`define CLUSTER_SIZE_RANK_MAPPER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cluster size rank mapper check failed");

// The consequent holds in the cycle after the antecedent.
`define CSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cluster size rank mapper check failed");

`endif

FILE: design/csrm_pkg.sv
// Shared types and constants of the cluster size rank mapper.
// Used by the controller, the datapath and the top level.
package csrm_pkg;

    localparam int DEF_MAX_CLUSTERS = 1024;
    localparam int DEF_COUNT_BITS   = 16;

    localparam int ACT_W  = 2;
    localparam int ID_W   = 10;
    localparam int SIZE_W = 16;

    localparam logic [ACT_W-1:0] ACT_COUNT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CNT_WR,
        S_Q_SIZE,
        S_Q_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic clr_start;
        logic clr_step;
        logic cnt_wr;
        logic q_init;
        logic q_size;
        logic scan;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             id_in_store;
        logic             id_in_range;
        logic             clr_last;
        logic             scan_done;
        logic             out_free;
    } t_dp_sts;

endpackage

FILE: design/cluster_size_rank_mapper.sv
// Channel  | valid    | stall    | fields
// input    | i_valid  | o_stall  | i_action, i_cluster_id
// result   | o_valid  | i_stall  | o_new_id, o_cluster_size, o_out_of_range
//
// A count word passes through accept, store read and saturating write back.
// An in-range query reads its own count, then scans the stored counts, reading one
// stored count per cycle; an out-of-range query skips both.
// After reset and after a clear word the memory is zeroed one entry per cycle,
// all MAX_CLUSTERS entries, while o_stall stays high.
// A result held by i_stall stalls the input only once the next query result is ready.
// Top level of the cluster size rank mapper. Uses csrm_pkg, csrm_ctrl, csrm_dp
// and the assertion macros header.
module cluster_size_rank_mapper #(
    parameter int MAX_CLUSTERS = csrm_pkg::DEF_MAX_CLUSTERS,
    parameter int COUNT_BITS   = csrm_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [csrm_pkg::ACT_W-1:0]   i_action,
    input  logic [csrm_pkg::ID_W-1:0]    i_cluster_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [csrm_pkg::ID_W-1:0]    o_new_id,
    output logic [csrm_pkg::SIZE_W-1:0]  o_cluster_size,
    output logic                         o_out_of_range
);
    import csrm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    oor_fields_zero;

    csrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    csrm_dp #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_cluster_id   (i_cluster_id),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_new_id       (o_new_id),
        .o_cluster_size (o_cluster_size),
        .o_out_of_range (o_out_of_range)
    );

    assign oor_fields_zero = (o_new_id == '0) && (o_cluster_size == '0);

`include "cluster_size_rank_mapper_macros.svh"

    `CSRM_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, cmd.out_load, sts.out_free)
    `CSRM_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, cmd.clr_step, o_stall)
    `CSRM_ASSERT_SAME(a_oor_zero_fields, i_clk, i_rst_n, o_valid && o_out_of_range, oor_fields_zero)
    `CSRM_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, cmd.out_load, o_valid)

endmodule

FILE: design/csrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module csrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/csrm_ctrl.sv
// Controller state machine of the cluster size rank mapper.
// Uses csrm_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts.
module csrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  csrm_pkg::t_dp_sts i_sts,
    output csrm_pkg::t_dp_cmd o_cmd
);
    import csrm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_sts.act)
                    ACT_COUNT: n_state = i_sts.id_in_store ? S_CNT_WR : S_IDLE;
                    ACT_QUERY: n_state = i_sts.id_in_range ? S_Q_SIZE : S_OUT;
                    ACT_CLEAR: n_state = S_CLEAR;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_CNT_WR: n_state = S_IDLE;
            S_Q_SIZE: n_state = S_Q_SCAN;
            S_Q_SCAN: begin
                if (i_sts.scan_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.latch_in = i_valid;
            end
            S_DECODE: begin
                o_cmd.clr_start = (i_sts.act == ACT_CLEAR);
                o_cmd.q_init    = (i_sts.act == ACT_QUERY);
            end
            S_CNT_WR: o_cmd.cnt_wr = 1'b1;
            S_Q_SIZE: o_cmd.q_size = 1'b1;
            S_Q_SCAN: o_cmd.scan = 1'b1;
            S_OUT:    o_cmd.out_load = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

FILE: design/csrm_dp.sv
// Datapath of the cluster size rank mapper: count store, cluster total,
// rank scan and result register. Uses csrm_pkg and csrm_ram.
module csrm_dp #(
    parameter int MAX_CLUSTERS = csrm_pkg::DEF_MAX_CLUSTERS,
    parameter int COUNT_BITS   = csrm_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csrm_pkg::t_dp_cmd            i_cmd,
    output csrm_pkg::t_dp_sts            o_sts,
    input  logic [csrm_pkg::ACT_W-1:0]   i_action,
    input  logic [csrm_pkg::ID_W-1:0]    i_cluster_id,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [csrm_pkg::ID_W-1:0]    o_new_id,
    output logic [csrm_pkg::SIZE_W-1:0]  o_cluster_size,
    output logic                         o_out_of_range
);
    import csrm_pkg::*;

    localparam int AW  = $clog2(MAX_CLUSTERS);
    localparam int TW  = $clog2(MAX_CLUSTERS + 1);
    localparam int RKW = (AW > ID_W) ? AW : ID_W;

    logic [ACT_W-1:0]      r_act;
    logic [ID_W-1:0]       r_id;
    logic [TW-1:0]         r_total;
    logic [TW-1:0]         r_j;
    logic [AW-1:0]         r_jd;
    logic                  r_pv;
    logic [COUNT_BITS-1:0] r_size;
    logic [RKW-1:0]        r_rank;
    logic                  r_oor;
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_new_id;
    logic [SIZE_W-1:0]     r_out_size;
    logic                  r_out_oor;

    logic [AW-1:0]         id_addr;
    logic [AW-1:0]         ram_raddr;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_we;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] sat_inc;
    logic                  scan_done;
    logic                  rank_hit;
    logic                  total_grow;
    logic [TW-1:0]         id_next;
    logic [31:0]           size_wide;
    logic [SIZE_W-1:0]     size_clip;
    logic                  out_free;

    assign id_addr    = AW'(r_id);
    assign scan_done  = (r_j == r_total);
    assign sat_inc    = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    assign id_next    = TW'(32'(r_id) + 32'd1);
    assign total_grow = (32'(r_id) + 32'd1) > 32'(r_total);
    assign rank_hit   = (ram_rdata > r_size) ||
                        ((ram_rdata == r_size) && (32'(r_jd) < 32'(r_id)));
    assign size_wide  = 32'(r_size);
    assign size_clip  = (size_wide > 32'h0000_FFFF) ? 16'hFFFF : size_wide[SIZE_W-1:0];
    assign out_free   = !r_out_valid || !i_stall;

    assign ram_raddr = i_cmd.scan ? r_j[AW-1:0] : id_addr;
    assign ram_we    = i_cmd.clr_step || i_cmd.cnt_wr;
    assign ram_waddr = i_cmd.clr_step ? r_j[AW-1:0] : id_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : sat_inc;

    csrm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_CLUSTERS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j         <= '0;
            r_total     <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan && !scan_done;
            if (i_cmd.clr_start) begin
                r_j     <= '0;
                r_total <= '0;
            end
            if (i_cmd.clr_step) begin
                r_j <= r_j + TW'(1);
            end
            if (i_cmd.cnt_wr && total_grow) begin
                r_total <= id_next;
            end
            if (i_cmd.q_size) begin
                r_j <= '0;
            end
            if (i_cmd.scan && !scan_done) begin
                r_j <= r_j + TW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_act <= i_action;
            r_id  <= i_cluster_id;
        end
        if (i_cmd.q_init) begin
            r_size <= '0;
            r_rank <= '0;
            r_oor  <= !(32'(r_id) < 32'(r_total));
        end
        if (i_cmd.q_size) begin
            r_size <= ram_rdata;
        end
        if (i_cmd.scan && !scan_done) begin
            r_jd <= r_j[AW-1:0];
        end
        if (r_pv && rank_hit) begin
            r_rank <= r_rank + RKW'(1);
        end
        if (i_cmd.out_load) begin
            r_new_id   <= r_rank[ID_W-1:0];
            r_out_size <= size_clip;
            r_out_oor  <= r_oor;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.act         = r_act;
        o_sts.id_in_store = 32'(r_id) < 32'(MAX_CLUSTERS);
        o_sts.id_in_range = 32'(r_id) < 32'(r_total);
        o_sts.clr_last    = (r_j == TW'(MAX_CLUSTERS - 1));
        o_sts.scan_done   = scan_done;
        o_sts.out_free    = out_free;
    end

    assign o_valid        = r_out_valid;
    assign o_new_id       = r_new_id;
    assign o_cluster_size = r_out_size;
    assign o_out_of_range = r_out_oor;

endmodule

FILE: tb/cluster_size_rank_mapper_tb.sv
// Self-checking testbench for cluster_size_rank_mapper: directed probes, clears,
// random count, query and clear words under varying idling, and a result hold-off.
// Depends on csrm_pkg and the cluster_size_rank_mapper RTL; needs no files at run time.
module cluster_size_rank_mapper_tb;

    import csrm_pkg::*;

    localparam int N_IDS = DEF_MAX_CLUSTERS;
    localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ID_W-1:0]   new_id;
        logic [SIZE_W-1:0] cluster_size;
        logic              oor;
    } rank_result_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  id;
        logic             typed;
        rank_result_t     want;
    } probe_row_t;

    localparam rank_result_t NO_WANT = '0;
    localparam rank_result_t EMPTY_OOR = '{new_id: '0, cluster_size: '0, oor: 1'b1};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [ACT_W-1:0]  i_action = ACT_COUNT;
    logic [ID_W-1:0]   i_cluster_id = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [ID_W-1:0]   o_new_id;
    logic [SIZE_W-1:0] o_cluster_size;
    logic              o_out_of_range;

    logic [DEF_COUNT_BITS-1:0] member_size [N_IDS];
    int                        cluster_count = 0;
    rank_result_t              expected_ranks [$];

    int n_errors = 0;
    int n_words_sent = 0;
    int n_results_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit pressure_armed = 1'b0;
    bit pressure_taken = 1'b0;
    int small_spans [5] = '{1, 3, 7, 15, 31};

    probe_row_t probes [25] = '{
        '{ACT_QUERY,  10'd0,    1'b1, EMPTY_OOR},
        '{ACT_QUERY,  10'd1023, 1'b1, EMPTY_OOR},
        '{ACT_COUNT,  10'd0,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd0,    1'b1, '{10'd0, 16'd1, 1'b0}},
        '{ACT_QUERY,  10'd1,    1'b1, EMPTY_OOR},
        '{ACT_COUNT,  10'd1023, 1'b0, NO_WANT},
        '{ACT_QUERY,  10'd1023, 1'b1, '{10'd1, 16'd1, 1'b0}},
        '{ACT_QUERY,  10'd512,  1'b0, NO_WANT},
        '{ACT_COUNT,  10'd1023, 1'b0, NO_WANT},
        '{ACT_QUERY,  10'd1023, 1'b1, '{10'd0, 16'd2, 1'b0}},
        '{ACT_QUERY,  10'd0,    1'b1, '{10'd1, 16'd1, 1'b0}},
        '{ACT_UNUSED, 10'd1023, 1'b0, NO_WANT},
        '{ACT_UNUSED, 10'd0,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd1022, 1'b0, NO_WANT},
        '{ACT_CLEAR,  10'h2AA,  1'b0, NO_WANT},
        '{ACT_QUERY,  10'd0,    1'b1, EMPTY_OOR},
        '{ACT_COUNT,  10'd5,    1'b0, NO_WANT},
        '{ACT_COUNT,  10'd5,    1'b0, NO_WANT},
        '{ACT_COUNT,  10'd3,    1'b0, NO_WANT},
        '{ACT_COUNT,  10'd7,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd3,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd7,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd6,    1'b0, NO_WANT},
        '{ACT_QUERY,  10'd8,    1'b1, EMPTY_OOR},
        '{ACT_QUERY,  10'h155,  1'b1, EMPTY_OOR}
    };

    cluster_size_rank_mapper DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_cluster_id   (i_cluster_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_new_id       (o_new_id),
        .o_cluster_size (o_cluster_size),
        .o_out_of_range (o_out_of_range)
    );

    always #1 i_clk = ~i_clk;

    function automatic void update_histogram(input logic [ACT_W-1:0] act,
                                             input logic [ID_W-1:0] id);
        rank_result_t r;
        int unsigned  pos;
        logic [DEF_COUNT_BITS-1:0] mine;
        r = EMPTY_OOR;
        pos = 0;
        if (act == ACT_COUNT) begin
            if (member_size[id] != COUNT_MAX) begin
                member_size[id] = member_size[id] + 1'b1;
            end
            if (int'(id) + 1 > cluster_count) begin
                cluster_count = int'(id) + 1;
            end
        end else if (act == ACT_CLEAR) begin
            foreach (member_size[j]) member_size[j] = '0;
            cluster_count = 0;
        end else if (act == ACT_QUERY) begin
            if (int'(id) < cluster_count) begin
                mine = member_size[id];
                for (int j = 0; j < cluster_count; j++) begin
                    if (member_size[j] > mine || (member_size[j] == mine && j < int'(id))) begin
                        pos++;
                    end
                end
                r.new_id = pos[ID_W-1:0];
                r.cluster_size = mine;
                r.oor = 1'b0;
            end
            expected_ranks.push_back(r);
        end
    endfunction

    task automatic push_word(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id);
        i_valid      <= 1'b1;
        i_action     <= act;
        i_cluster_id <= id;
        do @(posedge i_clk); while (o_stall);
        update_histogram(act, id);
        n_words_sent++;
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_all_ranks();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_ranks.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_words(input int quota);
        int sent;
        int span;
        int pick;
        int lim;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            span = (pick < 80) ? small_spans[$urandom_range(4)] : ((pick < 92) ? 255 : N_IDS - 1);
            lim = (span + 2 > N_IDS - 1) ? N_IDS - 1 : span + 2;
            if ($urandom_range(99) < 80) begin
                push_word(ACT_CLEAR, ID_W'($urandom));
                sent++;
                sender_gap();
            end
            repeat ($urandom_range(30, 8)) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    push_word(ACT_UNUSED, ID_W'($urandom));
                end else if (pick < 12) begin
                    push_word(ACT_QUERY, ID_W'($urandom));
                    sent++;
                end else if (pick < 60) begin
                    push_word(ACT_COUNT, ID_W'($urandom_range(span)));
                    sent++;
                end else begin
                    push_word(ACT_QUERY, ID_W'($urandom_range(lim)));
                    sent++;
                end
                sender_gap();
            end
        end
    endtask

    // The receiver idles at random, or holds off for a long stretch once asked to.
    always @(posedge i_clk) begin
        if (pressure_armed && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        rank_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_ranks.size() == 0) begin
                $error("result word with no query pending: new_id %0d size %0d oor %0b",
                       o_new_id, o_cluster_size, o_out_of_range);
                n_errors++;
            end else begin
                want = expected_ranks.pop_front();
                n_results_checked++;
                if (o_new_id !== want.new_id) begin
                    $error("new_id: expected %0d, got %0d", want.new_id, o_new_id);
                    n_errors++;
                end
                if (o_cluster_size !== want.cluster_size) begin
                    $error("cluster_size: expected %0d, got %0d",
                           want.cluster_size, o_cluster_size);
                    n_errors++;
                end
                if (o_out_of_range !== want.oor) begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, o_out_of_range);
                    n_errors++;
                end
            end
        end
    end

    initial begin : stimulus
        foreach (member_size[j]) member_size[j] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k]) begin
            push_word(probes[k].act, probes[k].id);
            if (probes[k].typed) begin
                expected_ranks[expected_ranks.size() - 1] = probes[k].want;
            end
        end
        wait_all_ranks();

        send_idle_pct = 7;
        recv_idle_pct = 83;
        run_random_words(155);
        wait_all_ranks();

        send_idle_pct = 83;
        recv_idle_pct = 7;
        run_random_words(155);
        wait_all_ranks();

        // The receiver holds off while words keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_word(ACT_CLEAR, '0);
        push_word(ACT_COUNT, 10'd4);
        pressure_armed = 1'b1;
        for (int k = 0; k < 24; k++) begin
            if (k % 3 == 0) begin
                push_word(ACT_QUERY, ID_W'($urandom_range(6)));
            end else begin
                push_word(ACT_COUNT, ID_W'($urandom_range(5)));
            end
        end
        wait_all_ranks();

        run_random_words(150);
        wait_all_ranks();
        repeat (1100) @(posedge i_clk);

        $display("summary: %0d words accepted, %0d query results compared;", n_words_sent,
                 n_results_checked);
        $display("summary: covered clears, ignored codes, out-of-range queries, hold-off.");
        if (n_errors == 0) begin
            $display("cluster_size_rank_mapper_tb: done, clean");
        end else begin
            $display("cluster_size_rank_mapper_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("cluster_size_rank_mapper_tb: done, errors");
        $finish;
    end

endmodule
